/* hdl/qlu_pkg.sv */
// Shared types and constants for the quoted literal unescaper.
package qlu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPEN1 = 3'd1,
    PH_OPEN2 = 3'd2,
    PH_BODY  = 3'd3,
    PH_ESC   = 3'd4,
    PH_HEX   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NO_OPEN = 3'd1,
    ERR_UNTERM  = 3'd2,
    ERR_NEWLINE = 3'd3,
    ERR_BAD_HEX = 3'd4,
    ERR_BAD_ESC = 3'd5
  } err_t;

  // One command: either one to four content bytes, or a single closing result.
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] data;
    logic            finish;
    err_t            err;
    logic            ret;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } wr_req_t;

endpackage

/* hdl/qlu_front.sv */
// Front end: parses source bytes, tracks literal state, issues commands.
module qlu_front import qlu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output wr_req_t    wr
);

  phase_t      phase, phase_next;
  logic        quote_is_single, quote_is_single_next;
  logic        long_form, long_form_next;
  logic [1:0]  pending_quotes, pending_quotes_next;
  logic [27:0] code_point, code_point_next;
  logic [3:0]  hex_digits_left, hex_digits_left_next;

  logic [7:0]  q;
  logic        is_q, is_bs, is_nl;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [31:0] v;
  logic        hex_done;
  logic        body_fin;
  err_t        body_err;
  wr_req_t     body_wr, esc_wr, hex_wr;
  err_t        eoi_err;

  function automatic cmd_t finish_cmd(input err_t e, input logic r);
    cmd_t c;
    c          = '0;
    c.finish   = 1'b1;
    c.err      = e;
    c.ret      = r;
    return c;
  endfunction

  function automatic cmd_t byte_cmd(input logic [7:0] b);
    cmd_t c;
    c         = '0;
    c.data[0] = b;
    return c;
  endfunction

  assign q     = quote_is_single ? CH_SQUOTE : CH_DQUOTE;
  assign is_q  = (in_byte == q);
  assign is_bs = (in_byte == CH_BSLASH);
  assign is_nl = (in_byte == CH_LF) || (in_byte == CH_CR);

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign v        = {code_point, hex_d};
  assign hex_done = (hex_digits_left <= 4'd1);

  // Content byte in the body
  assign body_fin = long_form ? (is_q && pending_quotes == 2'd2) : (is_q || is_nl);
  assign body_err = (!long_form && !is_q) ? ERR_NEWLINE : ERR_NONE;

  always_comb begin
    logic [2:0] n;
    n       = {1'b0, pending_quotes} + {2'b00, !is_bs};
    body_wr = '0;
    if (body_fin) begin
      body_wr.valid = 1'b1;
      body_wr.cmd   = finish_cmd(body_err, 1'b0);
    end else if (!(long_form && is_q)) begin
      // held quotes go out ahead of the byte
      body_wr.valid        = (n != 3'd0);
      body_wr.cmd.last_idx = n[1:0] - 2'd1;
      for (int i = 0; i < 4; i++) begin
        body_wr.cmd.data[i] = (i < int'(pending_quotes)) ? q : in_byte;
      end
    end
  end

  always_comb begin
    esc_wr       = '0;
    esc_wr.valid = 1'b1;
    case (in_byte)
      8'h74:     esc_wr.cmd = byte_cmd(8'h09);
      8'h62:     esc_wr.cmd = byte_cmd(8'h08);
      8'h6E:     esc_wr.cmd = byte_cmd(8'h0A);
      8'h72:     esc_wr.cmd = byte_cmd(8'h0D);
      8'h66:     esc_wr.cmd = byte_cmd(8'h0C);
      CH_DQUOTE: esc_wr.cmd = byte_cmd(CH_DQUOTE);
      CH_SQUOTE: esc_wr.cmd = byte_cmd(CH_SQUOTE);
      CH_BSLASH: esc_wr.cmd = byte_cmd(CH_BSLASH);
      8'h75, 8'h55: esc_wr.valid = 1'b0;
      default:   esc_wr.cmd = finish_cmd(ERR_BAD_ESC, 1'b0);
    endcase
  end

  // UTF-8 encode of the completed code point, or an error result on a bad hex digit
  always_comb begin
    hex_wr = '0;
    if (!hex_ok) begin
      hex_wr.valid = 1'b1;
      hex_wr.cmd   = finish_cmd(ERR_BAD_HEX, 1'b0);
    end else if (hex_done) begin
      hex_wr.valid = 1'b1;
      if (v < 32'h80) begin
        hex_wr.cmd.last_idx = 2'd0;
        hex_wr.cmd.data[0]  = v[7:0];
      end else if (v < 32'h800) begin
        hex_wr.cmd.last_idx = 2'd1;
        hex_wr.cmd.data[0]  = 8'hC0 | {3'b000, v[10:6]};
        hex_wr.cmd.data[1]  = 8'h80 | {2'b00, v[5:0]};
      end else if (v < 32'h10000) begin
        hex_wr.cmd.last_idx = 2'd2;
        hex_wr.cmd.data[0]  = 8'hE0 | {4'h0, v[15:12]};
        hex_wr.cmd.data[1]  = 8'h80 | {2'b00, v[11:6]};
        hex_wr.cmd.data[2]  = 8'h80 | {2'b00, v[5:0]};
      end else begin
        hex_wr.cmd.last_idx = 2'd3;
        hex_wr.cmd.data[0]  = 8'hF0 | v[25:18];
        hex_wr.cmd.data[1]  = 8'h80 | {2'b00, v[17:12]};
        hex_wr.cmd.data[2]  = 8'h80 | {2'b00, v[11:6]};
        hex_wr.cmd.data[3]  = 8'h80 | {2'b00, v[5:0]};
      end
    end
  end

  always_comb begin
    case (phase)
      PH_IDLE:  eoi_err = ERR_NO_OPEN;
      PH_OPEN2: eoi_err = ERR_NONE;
      PH_ESC:   eoi_err = ERR_BAD_ESC;
      PH_HEX:   eoi_err = ERR_BAD_HEX;
      default:  eoi_err = ERR_UNTERM;
    endcase
  end

  // Command output
  always_comb begin
    wr = '0;
    if (accept) begin
      if (end_of_input) begin
        wr.valid = 1'b1;
        wr.cmd   = finish_cmd(eoi_err, 1'b0);
      end else begin
        case (phase)
          PH_IDLE: begin
            if (in_byte != CH_DQUOTE && in_byte != CH_SQUOTE) begin
              wr.valid = 1'b1;
              wr.cmd   = finish_cmd(ERR_NO_OPEN, 1'b0);
            end
          end
          PH_OPEN1: begin
            if (!is_q) wr = body_wr;
          end
          PH_OPEN2: begin
            if (!is_q) begin
              wr.valid = 1'b1;
              wr.cmd   = finish_cmd(ERR_NONE, 1'b1);
            end
          end
          PH_BODY: wr = body_wr;
          PH_ESC:  wr = esc_wr;
          PH_HEX:  wr = hex_wr;
          default: wr = '0;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    logic clear;
    clear                = 1'b0;
    phase_next           = phase;
    quote_is_single_next = quote_is_single;
    long_form_next       = long_form;
    pending_quotes_next  = pending_quotes;
    code_point_next      = code_point;
    hex_digits_left_next = hex_digits_left;
    if (accept) begin
      if (end_of_input) begin
        clear = 1'b1;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (in_byte != CH_DQUOTE && in_byte != CH_SQUOTE) begin
              clear = 1'b1;
            end else begin
              quote_is_single_next = (in_byte == CH_SQUOTE);
              long_form_next       = 1'b0;
              pending_quotes_next  = 2'd0;
              phase_next           = PH_OPEN1;
            end
          end
          PH_OPEN1, PH_BODY: begin
            if (phase == PH_OPEN1 && is_q) begin
              phase_next = PH_OPEN2;
            end else if (body_fin) begin
              clear = 1'b1;
            end else if (long_form && is_q) begin
              phase_next          = PH_BODY;
              pending_quotes_next = pending_quotes + 2'd1;
            end else begin
              pending_quotes_next = 2'd0;
              phase_next          = is_bs ? PH_ESC : PH_BODY;
            end
          end
          PH_OPEN2: begin
            if (is_q) begin
              long_form_next      = 1'b1;
              pending_quotes_next = 2'd0;
              phase_next          = PH_BODY;
            end else begin
              clear = 1'b1;
            end
          end
          PH_ESC: begin
            if (in_byte == 8'h75 || in_byte == 8'h55) begin
              phase_next           = PH_HEX;
              code_point_next      = '0;
              hex_digits_left_next = (in_byte == 8'h75) ? 4'd4 : 4'd8;
            end else if (esc_wr.cmd.finish) begin
              clear = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end
          PH_HEX: begin
            if (!hex_ok) begin
              clear = 1'b1;
            end else begin
              if (hex_digits_left != 4'd0) hex_digits_left_next = hex_digits_left - 4'd1;
              if (hex_done) begin
                phase_next      = PH_BODY;
                code_point_next = '0;
              end else begin
                code_point_next = v[27:0];
              end
            end
          end
          default: clear = 1'b1;
        endcase
      end
    end
    if (clear) begin
      phase_next           = PH_IDLE;
      quote_is_single_next = 1'b0;
      long_form_next       = 1'b0;
      pending_quotes_next  = 2'd0;
      code_point_next      = '0;
      hex_digits_left_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      quote_is_single <= 1'b0;
      long_form       <= 1'b0;
      pending_quotes  <= 2'd0;
      code_point      <= '0;
      hex_digits_left <= 4'd0;
    end else begin
      phase           <= phase_next;
      quote_is_single <= quote_is_single_next;
      long_form       <= long_form_next;
      pending_quotes  <= pending_quotes_next;
      code_point      <= code_point_next;
      hex_digits_left <= hex_digits_left_next;
    end
  end

endmodule

/* hdl/qlu_queue.sv */
// Command queue between the front end and the output stage.
module qlu_queue import qlu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  wr_req_t wr,
  input  logic    rd,
  output cmd_t    head,
  output logic    q_empty,
  output logic    q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == CNT_W'(DEPTH));
  assign do_wr   = wr.valid && !q_full;
  assign do_rd   = rd && !q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

endmodule

/* hdl/qlu_back.sv */
// Output stage: expands each command into result items, one per cycle while pop is held.
module qlu_back import qlu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [2:0] error_code,
  output logic       byte_returned
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       done;

  assign done  = cur_valid && pop && (idx == cur.last_idx);
  assign rd    = !q_empty && (!cur_valid || done);
  assign empty = !cur_valid;

  assign out_byte      = cur.finish ? 8'h00 : cur.data[idx];
  assign byte_valid    = !cur.finish;
  assign last          = cur.finish;
  assign error_code    = cur.finish ? cur.err : ERR_NONE;
  assign byte_returned = cur.ret;

  always_ff @(posedge clk) begin
    if (rd) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (rd) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (cur_valid && pop) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

/* hdl/quoted_literal_unescape_utf8.sv */
// Top level of the quoted literal unescaper.
// A request's command is written into the queue on the accepting edge, then
// loaded into the output register, which drives the result ports.
// Throughput: one request per cycle while full is low; results leave at one
// per cycle while pop is held; a hex escape yields up to four bytes.
// Reset (rst, synchronous): parser back to idle, queue and output empty.
module quoted_literal_unescape_utf8 import qlu_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [2:0] error_code,
  output logic       byte_returned
);

  wr_req_t wr;
  cmd_t    head;
  logic    q_empty, q_full, rd, accept;

  // push stalls (full) once the command queue of QUEUE_DEPTH entries is full
  assign full   = q_full;
  assign accept = push && !q_full;

  qlu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .wr           (wr)
  );

  qlu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  qlu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .rd            (rd),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .error_code    (error_code),
    .byte_returned (byte_returned)
  );

endmodule
